/* design/bitmap_coprocessor_cmd_queue_macros.svh */
// Assertion helpers shared by the checker.
`ifndef BITMAP_COPROCESSOR_CMD_QUEUE_MACROS_SVH
`define BITMAP_COPROCESSOR_CMD_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BCQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bcq: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BCQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bcq: assertion failed");

`endif

/* design/bcq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcq_pkg
// Opcodes, command bytes, buffer port type and small helpers of the
// bitmap coprocessor command queue.
// ----------------------------------------------------------------------------
package bcq_pkg;

	localparam int BUF_AW = 8;
	localparam int ENTRY_W = 20;

	localparam logic [3:0] OP_DISPATCH = 4'h0;
	localparam logic [3:0] OP_SCATTER  = 4'h1;
	localparam logic [3:0] OP_KEY      = 4'h2;
	localparam logic [3:0] OP_COUNT    = 4'h3;
	localparam logic [3:0] OP_FILL     = 4'h4;
	localparam logic [3:0] OP_MERGE    = 4'h5;
	localparam logic [3:0] OP_SWAPCNT  = 4'h6;
	localparam logic [3:0] OP_SWAP     = 4'h7;
	localparam logic [3:0] OP_MUL      = 4'h8;
	localparam logic [3:0] OP_ORIG     = 4'h9;
	localparam logic [3:0] OP_NEW      = 4'hA;
	localparam logic [3:0] OP_SCALE    = 4'hB;

	localparam logic [7:0] CMD_SCATTER = 8'h01;
	localparam logic [7:0] CMD_KEY     = 8'h03;
	localparam logic [7:0] CMD_MERGE   = 8'h05;
	localparam logic [7:0] CMD_SWAP    = 8'h06;
	localparam logic [7:0] CMD_MUL     = 8'h09;
	localparam logic [7:0] CMD_SCALE   = 8'h0D;
	localparam logic [7:0] CMD_NOP     = 8'h0F;

	localparam logic [7:0] ADDR_HI   = 8'h80;
	localparam logic [1:0] MUL_LAST  = 2'd3;

	typedef struct packed {
		logic              re;
		logic [BUF_AW-1:0] raddr;
		logic              we;
		logic [BUF_AW-1:0] waddr;
		logic [7:0]        wdata;
	} buf_req_t;

	function automatic logic [7:0] half_signed(input logic [7:0] v);
		return {v[7], v[7:1]};
	endfunction

	// byte touched by column pair j of a scatter entry
	function automatic logic [7:0] scatter_byte(input logic [7:0] lo, input logic [1:0] j);
		return {3'b000, j[1], lo[4:2], j[0]};
	endfunction

	function automatic logic [7:0] scatter_merge(input logic [7:0] cur, input logic [1:0] lo2,
			input logic bl, input logic bh);
		logic [2:0] pos;
		logic [7:0] r;
		pos = 3'd6 - {lo2, 1'b0};
		r = cur;
		r[pos] = bl;
		r[pos + 3'd1] = bh;
		return r;
	endfunction

	function automatic logic [7:0] nibble_merge(input logic [7:0] cur, input logic [7:0] v,
			input logic [3:0] key);
		logic [7:0] r;
		r = cur;
		if (v[7:4] != key) r[7:4] = v[7:4];
		if (v[3:0] != key) r[3:0] = v[3:0];
		return r;
	endfunction

endpackage

/* design/bcq_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcq_req_if
// Bus access request channel: kind, address and write byte.
// ----------------------------------------------------------------------------
interface bcq_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] address;
	logic [7:0]  write_data;

	modport source(output valid, kind, address, write_data, input ready);
	modport sink(input valid, kind, address, write_data, output ready);
endinterface

/* design/bcq_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcq_rsp_if
// Bus access response channel: read byte and halt status.
// ----------------------------------------------------------------------------
interface bcq_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       halted;

	modport source(output valid, read_data, halted, input ready);
	modport sink(input valid, read_data, halted, output ready);
endinterface

/* design/bcq_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcq_buffer
// 256-byte data buffer, one write and one registered read per cycle.
// Per-byte valid bits make unwritten bytes read as zero after reset.
// ----------------------------------------------------------------------------
module bcq_buffer (
	input  logic              clk,
	input  logic              arst_n,
	input  bcq_pkg::buf_req_t ctl,
	output logic [7:0]        rdata
);
	import bcq_pkg::*;

	localparam int DEPTH = 1 << BUF_AW;

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       mem_rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		if (ctl.re) begin
			mem_rd_q <= mem[ctl.raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.we) vld_q[ctl.waddr] <= 1'b1;
			if (ctl.re) rd_vld_q <= vld_q[ctl.raddr];
		end
	end

	assign rdata = rd_vld_q ? mem_rd_q : 8'h00;
endmodule

/* design/bitmap_coprocessor_cmd_queue.sv */
`timescale 1ns / 1ps
// A read runs the product shift when it is armed; a halted request or a bad read address
// goes straight to the response. A write may queue entries (up to 511 entries), and
// scaling runs the restoring divider first. One request is in work at a time.
// Reset: halt cleared, buffer bytes read zero through valid bits, queue slot zero reads as
// a dispatcher at 0x8000 until it is written; other queue slots are undefined until written.
// ----------------------------------------------------------------------------
// bitmap_coprocessor_cmd_queue
// Command-queue driven bitmap helper on a byte bus, run by a small sequencer.
// ----------------------------------------------------------------------------
module bitmap_coprocessor_cmd_queue #(
	parameter int QUEUE_DEPTH = 512
) (
	input  logic      clk,
	input  logic      arst_n,
	bcq_req_if.sink   req,
	bcq_rsp_if.source rsp
);
	import bcq_pkg::*;

	localparam int QW = $clog2(QUEUE_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_WAIT, ST_SHIFT, ST_SHIFT3, ST_Q_WAIT, ST_EXEC, ST_ENQ,
		ST_SCAT, ST_MRG, ST_MUL_A, ST_MUL_B, ST_MUL_W, ST_DIV, ST_FIN, ST_DONE
	} state_t;

	state_t state_q;

	logic [ENTRY_W-1:0] qmem [QUEUE_DEPTH];
	logic [ENTRY_W-1:0] qrd_q;
	logic               qz_q;
	logic               q0_wr_q;
	logic               q_we;
	logic [ENTRY_W-1:0] q_wdata;

	logic [QW-1:0] rp_q, wp_q;
	logic          halt_q, auto_q, skip_q;
	logic [3:0]    key_q;
	logic [7:0]    orig_q;

	logic [15:0] addr_q;
	logic [7:0]  v_q, rd_q;
	logic [3:0]  op_q, op_e_q;
	logic [7:0]  param_q, lo_q;
	logic        more_q, ph2_q;
	logic [2:0]  step_q;
	logic [7:0]  i_q, n_q, q_q, r_q, mul_a_q, sext_q, dvd_q, rem_q;
	logic [15:0] prod_q;

	logic        rsp_valid_q, rsp_halt_q;
	logic [7:0]  rsp_data_q;

	buf_req_t   bctl;
	logic [7:0] brd;

	logic       addr_ok, chk_ok;
	logic [7:0] e_param, e_lo, hs_v;
	logic [8:0] rem2, rs;
	logic [7:0] mul_byte;

	bcq_buffer u_buf (.clk(clk), .arst_n(arst_n), .ctl(bctl), .rdata(brd));

	assign req.ready     = (state_q == ST_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rsp_data_q;
	assign rsp.halted    = rsp_halt_q;

	assign addr_ok = req.address[15] && (req.address[14:12] == 3'b000);
	assign chk_ok  = skip_q || (addr_q == {ADDR_HI, lo_q});
	assign hs_v    = half_signed(v_q);
	assign rem2    = {rem_q, dvd_q[7]};
	assign rs      = {1'b0, r_q} + {1'b0, rem_q};

	always_comb begin
		case (step_q[1:0])
			2'd0:    mul_byte = prod_q[7:0];
			2'd1:    mul_byte = prod_q[15:8];
			default: mul_byte = 8'h00;
		endcase
	end

	// fields of the entry being queued
	always_comb begin
		case (op_e_q)
			OP_MUL:   e_param = i_q;
			OP_SWAP:  e_param = n_q - 8'd1 - i_q;
			OP_SCALE: e_param = q_q;
			default:  e_param = 8'h00;
		endcase
		case (op_e_q)
			OP_SCATTER, OP_FILL, OP_MERGE, OP_SWAP, OP_SCALE: e_lo = i_q;
			default: e_lo = 8'h00;
		endcase
	end

	always_comb begin
		q_we    = 1'b0;
		q_wdata = '0;
		if (state_q == ST_ENQ) begin
			if (i_q != n_q) begin
				q_we    = 1'b1;
				q_wdata = {op_e_q, e_param, e_lo};
			end else if (!ph2_q && more_q) begin
				q_we    = 1'b1;
				q_wdata = {OP_DISPATCH, 8'h00, 8'h00};
			end
		end
	end

	always_comb begin
		bctl = '0;
		case (state_q)
			ST_IDLE: begin
				bctl.re    = req.valid && !halt_q && !req.kind && addr_ok;
				bctl.raddr = req.address[7:0];
			end
			ST_RD_WAIT: begin
				bctl.re    = auto_q;
				bctl.raddr = 8'd1;
			end
			ST_SHIFT: begin
				bctl.we    = 1'b1;
				bctl.waddr = {5'd0, step_q};
				bctl.wdata = brd;
				bctl.re    = (step_q != 3'd2);
				bctl.raddr = {5'd0, step_q} + 8'd2;
			end
			ST_SHIFT3: begin
				bctl.we    = 1'b1;
				bctl.waddr = 8'd3;
				bctl.wdata = sext_q;
			end
			ST_EXEC: begin
				if (chk_ok) begin
					case (op_q)
						OP_FILL: begin
							bctl.we    = 1'b1;
							bctl.waddr = lo_q;
							bctl.wdata = v_q;
						end
						OP_SWAP: begin
							bctl.we    = 1'b1;
							bctl.waddr = param_q;
							bctl.wdata = {v_q[3:0], v_q[7:4]};
						end
						OP_MUL, OP_SCALE: begin
							bctl.we    = 1'b1;
							bctl.waddr = param_q;
							bctl.wdata = v_q;
							bctl.re    = (op_q == OP_MUL) && (param_q == {6'd0, MUL_LAST});
							bctl.raddr = 8'd0;
						end
						OP_SCATTER: begin
							bctl.re    = 1'b1;
							bctl.raddr = scatter_byte(lo_q, 2'd0);
						end
						OP_MERGE: begin
							bctl.re    = 1'b1;
							bctl.raddr = lo_q;
						end
						default: bctl = '0;
					endcase
				end
			end
			ST_SCAT: begin
				bctl.we    = 1'b1;
				bctl.waddr = scatter_byte(lo_q, step_q[1:0]);
				bctl.wdata = scatter_merge(brd, lo_q[1:0], v_q[{1'b0, step_q[1:0]}],
					v_q[{1'b1, step_q[1:0]}]);
				bctl.re    = (step_q[1:0] != 2'd3);
				bctl.raddr = scatter_byte(lo_q, step_q[1:0] + 2'd1);
			end
			ST_MRG: begin
				bctl.we    = 1'b1;
				bctl.waddr = lo_q;
				bctl.wdata = nibble_merge(brd, v_q, key_q);
			end
			ST_MUL_A: begin
				bctl.re    = 1'b1;
				bctl.raddr = 8'd2;
			end
			ST_MUL_W: begin
				bctl.we    = 1'b1;
				bctl.waddr = {6'd0, step_q[1:0]};
				bctl.wdata = mul_byte;
			end
			default: bctl = '0;
		endcase
	end

	// queue memory: write while queuing, read at the read pointer every cycle
	always_ff @(posedge clk) begin
		if (q_we) qmem[wp_q] <= q_wdata;
		qrd_q <= qmem[rp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			qz_q        <= 1'b0;
			q0_wr_q     <= 1'b0;
			rp_q        <= '0;
			wp_q        <= QW'(1);
			halt_q      <= 1'b0;
			auto_q      <= 1'b0;
			skip_q      <= 1'b0;
			key_q       <= '0;
			orig_q      <= '0;
			addr_q      <= '0;
			v_q         <= '0;
			rd_q        <= '0;
			op_q        <= '0;
			op_e_q      <= '0;
			param_q     <= '0;
			lo_q        <= '0;
			more_q      <= 1'b0;
			ph2_q       <= 1'b0;
			step_q      <= '0;
			i_q         <= '0;
			n_q         <= '0;
			q_q         <= '0;
			r_q         <= '0;
			mul_a_q     <= '0;
			sext_q      <= '0;
			dvd_q       <= '0;
			rem_q       <= '0;
			prod_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_halt_q  <= 1'b0;
			rsp_data_q  <= '0;
		end else begin
			qz_q <= (rp_q == '0) && !q0_wr_q;
			if (q_we) begin
				if (wp_q == '0) q0_wr_q <= 1'b1;
				wp_q <= (wp_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						addr_q <= req.address;
						v_q    <= req.write_data;
						rd_q   <= 8'h00;
						if (halt_q) state_q <= ST_DONE;
						else if (req.kind) state_q <= ST_Q_WAIT;
						else if (addr_ok) state_q <= ST_RD_WAIT;
						else state_q <= ST_DONE;
					end
				end
				ST_RD_WAIT: begin
					rd_q   <= brd;
					step_q <= '0;
					state_q <= auto_q ? ST_SHIFT : ST_DONE;
				end
				ST_SHIFT: begin
					if (step_q == 3'd2) begin
						sext_q  <= {8{brd[7]}};
						state_q <= ST_SHIFT3;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_SHIFT3: state_q <= ST_DONE;
				ST_Q_WAIT: begin
					op_q    <= qz_q ? OP_DISPATCH : qrd_q[19:16];
					param_q <= qz_q ? 8'h00 : qrd_q[15:8];
					lo_q    <= qz_q ? 8'h00 : qrd_q[7:0];
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					i_q    <= '0;
					ph2_q  <= 1'b0;
					step_q <= '0;
					if (!chk_ok) begin
						halt_q  <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						case (op_q)
							OP_DISPATCH: begin
								auto_q  <= 1'b0;
								skip_q  <= 1'b0;
								state_q <= ST_ENQ;
								case (v_q)
									CMD_SCATTER: begin
										op_e_q <= OP_SCATTER; n_q <= 8'd32; more_q <= 1'b1;
									end
									CMD_KEY: begin
										op_e_q <= OP_KEY; n_q <= 8'd1; more_q <= 1'b1;
									end
									CMD_MERGE: begin
										skip_q <= 1'b1;
										op_e_q <= OP_COUNT; n_q <= 8'd1; more_q <= 1'b0;
									end
									CMD_SWAP: begin
										op_e_q <= OP_SWAPCNT; n_q <= 8'd1; more_q <= 1'b0;
									end
									CMD_MUL: begin
										op_e_q <= OP_MUL; n_q <= 8'd4; more_q <= 1'b1;
									end
									CMD_SCALE: begin
										op_e_q <= OP_ORIG; n_q <= 8'd1; more_q <= 1'b0;
									end
									CMD_NOP: begin
										n_q <= 8'd0; more_q <= 1'b1;
									end
									default: begin
										halt_q  <= 1'b1;
										state_q <= ST_DONE;
									end
								endcase
							end
							OP_SCATTER: state_q <= ST_SCAT;
							OP_KEY: begin
								key_q   <= v_q[3:0];
								state_q <= ST_FIN;
							end
							OP_COUNT, OP_SWAPCNT: begin
								if (v_q == 8'h00) begin
									halt_q  <= 1'b1;
									state_q <= ST_DONE;
								end else begin
									op_e_q  <= (op_q == OP_COUNT) ? OP_FILL : OP_SWAP;
									ph2_q   <= (op_q == OP_COUNT);
									n_q     <= v_q;
									more_q  <= 1'b1;
									state_q <= ST_ENQ;
								end
							end
							OP_MERGE: state_q <= ST_MRG;
							OP_FILL, OP_SWAP, OP_SCALE: state_q <= ST_FIN;
							OP_MUL: begin
								state_q <= (param_q == {6'd0, MUL_LAST}) ? ST_MUL_A : ST_FIN;
							end
							OP_ORIG: begin
								orig_q <= hs_v;
								if (hs_v == 8'h00) begin
									halt_q  <= 1'b1;
									state_q <= ST_DONE;
								end else begin
									op_e_q  <= OP_NEW;
									n_q     <= 8'd1;
									more_q  <= 1'b0;
									state_q <= ST_ENQ;
								end
							end
							OP_NEW: begin
								if (hs_v == 8'h00) begin
									halt_q  <= 1'b1;
									state_q <= ST_DONE;
								end else begin
									dvd_q   <= hs_v;
									rem_q   <= 8'h00;
									state_q <= ST_DIV;
								end
							end
							default: begin
								halt_q  <= 1'b1;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_ENQ: begin
					if (i_q != n_q) begin
						i_q <= i_q + 8'd1;
						// step the scaled index: add quotient, carry the remainder
						if (rs >= {1'b0, orig_q}) begin
							r_q <= 8'(rs - {1'b0, orig_q});
							q_q <= q_q + dvd_q + 8'd1;
						end else begin
							r_q <= rs[7:0];
							q_q <= q_q + dvd_q;
						end
					end else if (ph2_q) begin
						op_e_q <= OP_MERGE;
						i_q    <= '0;
						ph2_q  <= 1'b0;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					if (rem2 >= {1'b0, orig_q}) begin
						rem_q <= 8'(rem2 - {1'b0, orig_q});
						dvd_q <= {dvd_q[6:0], 1'b1};
					end else begin
						rem_q <= rem2[7:0];
						dvd_q <= {dvd_q[6:0], 1'b0};
					end
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						op_e_q  <= OP_SCALE;
						n_q     <= orig_q;
						more_q  <= 1'b1;
						i_q     <= '0;
						q_q     <= '0;
						r_q     <= '0;
						state_q <= ST_ENQ;
					end
				end
				ST_SCAT: begin
					step_q <= step_q + 3'd1;
					if (step_q[1:0] == 2'd3) state_q <= ST_FIN;
				end
				ST_MRG: state_q <= ST_FIN;
				ST_MUL_A: begin
					mul_a_q <= brd;
					state_q <= ST_MUL_B;
				end
				ST_MUL_B: begin
					prod_q  <= mul_a_q * brd;
					step_q  <= '0;
					state_q <= ST_MUL_W;
				end
				ST_MUL_W: begin
					step_q <= step_q + 3'd1;
					if (step_q[1:0] == 2'd3) begin
						auto_q  <= 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					rp_q    <= (rp_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the response register is free
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_data_q  <= rd_q;
						rsp_halt_q  <= halt_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* design/bcq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcq_checker
// Port-level checks of the command queue block, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_coprocessor_cmd_queue_macros.svh"

module bcq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_read_data,
	input logic       rsp_halted
);
	logic [1:0] pend_q;
	logic       seen_halt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			seen_halt_q <= 1'b0;
		end else begin
			pend_q <= pend_q + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
			if (rsp_valid && rsp_ready && rsp_halted) seen_halt_q <= 1'b1;
		end
	end

	`BCQ_ASSERT_IMP(a_halt_reads_zero, rsp_valid && rsp_halted, rsp_read_data == 8'h00)
	`BCQ_ASSERT_IMP(a_halt_sticky, rsp_valid && seen_halt_q, rsp_halted)
	`BCQ_ASSERT_IMP(a_rsp_has_request, rsp_valid, pend_q != 2'd0)
	`BCQ_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data))
endmodule

bind bitmap_coprocessor_cmd_queue bcq_checker u_bcq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_read_data(rsp.read_data),
	.rsp_halted   (rsp.halted)
);
